// ----- hdl/aes128_block_cipher_macros.svh -----
// Assertion macros for the AES-128 block cipher.
`ifndef AES128_BLOCK_CIPHER_MACROS_SVH
`define AES128_BLOCK_CIPHER_MACROS_SVH
`ifndef SYNTHESIS
`define AES_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define AES_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define AES_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define AES_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ----- hdl/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// AES package
// Shared types, constants and GF(2^8) functions of the AES-128 cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int NumWords  = 44;
    localparam int NumRounds = 10;

    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    typedef logic [7:0]   byte_t;
    typedef logic [31:0]  word_t;
    typedef logic [127:0] block_t;
    typedef logic [5:0]   widx_t;

    typedef struct packed {
        logic  load;
        logic  decrypt;
        logic  last;
        logic  skip_mix;
    } cell_ctl_t;

    function automatic byte_t sbox(input byte_t a);
        byte_t t [256] = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic byte_t inv_sbox(input byte_t a);
        byte_t t [256] = '{
            8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
            8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
            8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
            8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
            8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
            8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
            8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
            8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
            8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
            8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
            8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
            8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
            8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
            8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
            8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
            8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        return t[a];
    endfunction

    function automatic byte_t xtime(input byte_t v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic word_t sub_word(input word_t x);
        return {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
    endfunction

    function automatic byte_t rcon(input logic [3:0] i);
        byte_t r;
        case (i)
            4'd0:    r = 8'h01;
            4'd1:    r = 8'h02;
            4'd2:    r = 8'h04;
            4'd3:    r = 8'h08;
            4'd4:    r = 8'h10;
            4'd5:    r = 8'h20;
            4'd6:    r = 8'h40;
            4'd7:    r = 8'h80;
            4'd8:    r = 8'h1b;
            4'd9:    r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/aes_stream_if.sv -----
// ----------------------------------------------------------------------------
// AES stream interfaces
// Valid/ready channels for blocks, results and configuration writes.
// ----------------------------------------------------------------------------
interface aes_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [63:0] block_high;
    logic [63:0] block_low;
    modport source (output valid, req_type, block_high, block_low, input ready);
    modport sink   (input valid, req_type, block_high, block_low, output ready);
endinterface

interface aes_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;
    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/aes_column_cell.sv -----
// ----------------------------------------------------------------------------
// AES column cell
// Holds one state column and, per cycle with step high, loads it or performs one round on it.
// ----------------------------------------------------------------------------
module aes_column_cell (
    input  logic              clk,
    // High in a round cycle; the column is held in every other cycle.
    input  logic              step,
    input  aes_pkg::cell_ctl_t ctl,
    input  aes_pkg::word_t    load_col,
    input  aes_pkg::word_t    key_col,
    // Bytes arriving from the neighbouring cells after the row shift.
    input  aes_pkg::word_t    shifted_col,
    output aes_pkg::word_t    col
);
    import aes_pkg::*;

    word_t col_reg;
    word_t col_next;
    byte_t s [4];
    byte_t m [4];
    byte_t k [4];
    byte_t a0, a1, a2, a3;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            s[r] = ctl.decrypt ? inv_sbox(shifted_col[31-8*r -: 8])
                               : sbox(shifted_col[31-8*r -: 8]);
            k[r] = key_col[31-8*r -: 8];
        end
        if (!ctl.decrypt)
        begin
            for (int r = 0; r < 4; r++)
            begin
                a0 = s[r];
                a1 = s[(r+1)%4];
                a2 = s[(r+2)%4];
                a3 = s[(r+3)%4];
                m[r] = ctl.skip_mix ? a0 ^ k[r]
                                    : xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3 ^ k[r];
            end
        end
        else
        begin
            for (int r = 0; r < 4; r++)
                s[r] = s[r] ^ k[r];
            for (int r = 0; r < 4; r++)
            begin
                a0 = s[r];
                a1 = s[(r+1)%4];
                a2 = s[(r+2)%4];
                a3 = s[(r+3)%4];
                // 0e,0b,0d,09 built from repeated doubling
                m[r] = ctl.skip_mix ? a0 :
                    (xtime(xtime(xtime(a0))) ^ xtime(xtime(a0)) ^ xtime(a0)) ^
                    (xtime(xtime(xtime(a1))) ^ xtime(a1) ^ a1) ^
                    (xtime(xtime(xtime(a2))) ^ xtime(xtime(a2)) ^ a2) ^
                    (xtime(xtime(xtime(a3))) ^ a3);
            end
        end
        col_next = ctl.load ? (load_col ^ key_col) : {m[0], m[1], m[2], m[3]};
    end

    always_ff @(posedge clk)
    begin
        if (step)
            col_reg <= col_next;
    end

    assign col = col_reg;

endmodule

// ----- hdl/aes_key_expand.sv -----
// ----------------------------------------------------------------------------
// AES key expansion
// Produces one round-key word per cycle into the round-key memory while busy.
// ----------------------------------------------------------------------------
module aes_key_expand (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [127:0]  key,
    input  aes_pkg::widx_t rd_addr,
    output aes_pkg::word_t rd_data,
    output logic          busy
);
    import aes_pkg::*;

    word_t mem [NumWords];
    word_t win_reg [4];
    word_t win_next [4];
    widx_t cnt_reg;
    widx_t cnt_next;
    logic  busy_reg;
    logic  busy_next;
    word_t t;
    word_t nw;
    word_t rd_reg;

    always_comb
    begin
        t = {win_reg[3][23:0], win_reg[3][31:24]};
        t = sub_word(t) ^ {rcon(cnt_reg[5:2] - 4'd1), 24'd0};
        if (cnt_reg < 6'd4)
            nw = key[127-32*cnt_reg[1:0] -: 32];
        else if (cnt_reg[1:0] == 2'd0)
            nw = win_reg[0] ^ t;
        else
            nw = win_reg[0] ^ win_reg[3];
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = win_reg[3];
        win_next[3] = nw;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(NumWords - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !start)
        begin
            win_reg     <= win_next;
            mem[cnt_reg] <= nw;
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;
    assign busy    = busy_reg;

endmodule

// ----- hdl/aes128_block_cipher.sv -----
// ----------------------------------------------------------------------------
// AES-128 block cipher
// ECB encrypt/decrypt of one 128-bit block per transaction.
// ----------------------------------------------------------------------------
// The block works on one transaction at a time. The state lives in a row of
// four column cells; in the first round cycle every cell loads its column of
// the input block with the initial key addition, in each later round cycle it
// takes the row-shifted bytes of its neighbours and completes one round on its
// own column, and in every other cycle the cells hold their columns. After
// reset or a key write the next transaction first runs key expansion: the 44
// round-key words are written one per cycle into a memory before the rounds
// begin. The round-key memory has a single registered read port that yields
// one word (one column) per cycle, so each of the eleven key additions (the
// initial one and the ten rounds) is preceded by a fetch of its four words
// into a round-key line whose words go to the four cells, and that read port
// sets the pace. No new transaction is accepted until the finished result has
// moved into the output register. The result waits in that register and a new
// transaction may be accepted meanwhile; the block only stalls when a finished
// result finds that register still occupied.
// ----------------------------------------------------------------------------
`include "aes128_block_cipher_macros.svh"

module aes128_block_cipher (
    input  logic clk,
    input  logic rst_n,
    aes_cfg_if.sink   cfg,
    aes_req_if.sink   req,
    aes_res_if.source res
);
    import aes_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXPND = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]   state_reg, state_next;
    logic [63:0]  key_hi_reg, key_lo_reg;
    logic         ready_keys_reg, ready_keys_next;
    logic         dec_reg;
    block_t       in_reg;
    logic [3:0]   round_reg, round_next;
    logic [1:0]   wsel_reg, wsel_next;
    logic         loaded_reg, loaded_next;
    word_t        rk_reg [3];
    word_t        rk_cur [4];
    word_t        cols [4];
    word_t        shifted [4];
    word_t        rk_data;
    widx_t        rk_addr;
    logic         exp_start, exp_busy;
    cell_ctl_t    ctl;
    logic         out_valid_reg;
    block_t       out_reg;
    logic         out_load;
    logic [3:0]   key_round;

    // Round index used for the key word being fetched.
    assign key_round = dec_reg ? 4'(NumRounds) - round_next : round_next;
    assign rk_addr   = widx_t'({key_round, 2'b00}) + widx_t'(wsel_reg);

    aes_key_expand u_expand (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (exp_start),
        .key     ({key_hi_reg, key_lo_reg}),
        .rd_addr (rk_addr),
        .rd_data (rk_data),
        .busy    (exp_busy)
    );

    assign cfg.ready = (state_reg == ST_IDLE);
    assign req.ready = (state_reg == ST_IDLE) && !cfg.valid;
    assign exp_start = (state_reg == ST_IDLE) && req.valid && req.ready && !ready_keys_reg;

    // A finished result moves to the output register once that is free or
    // being emptied in the same cycle.
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == REG_KEY_HIGH)
                key_hi_reg <= cfg.data;
            else
                key_lo_reg <= cfg.data;
        end
    end

    // Row shift across the cells: row r of column c comes from column c+r
    // (encrypt) or c-r (decrypt).
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                shifted[c][31-8*r -: 8] = dec_reg ? cols[(c + 4 - r) % 4][31-8*r -: 8]
                                                  : cols[(c + r) % 4][31-8*r -: 8];
    end

    // The last key word of the current round comes straight from the read port.
    always_comb
    begin
        rk_cur[0] = rk_reg[0];
        rk_cur[1] = rk_reg[1];
        rk_cur[2] = rk_reg[2];
        rk_cur[3] = rk_data;
    end

    always_comb
    begin
        state_next      = state_reg;
        round_next      = round_reg;
        wsel_next       = wsel_reg;
        loaded_next     = 1'b0;
        ready_keys_next = ready_keys_reg;
        ctl.load        = 1'b0;
        ctl.decrypt     = dec_reg;
        ctl.last        = 1'b0;
        ctl.skip_mix    = 1'b0;
        if (cfg.valid && cfg.ready)
            ready_keys_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    round_next = '0;
                    wsel_next  = '0;
                    if (!ready_keys_reg)
                        state_next = ST_EXPND;
                    else
                        state_next = ST_FETCH;
                end
            end
            ST_EXPND:
            begin
                if (!exp_busy)
                begin
                    ready_keys_next = 1'b1;
                    state_next      = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                // Four words of a round key, one per cycle.
                wsel_next = wsel_reg + 2'd1;
                if (wsel_reg == 2'd3)
                begin
                    loaded_next = 1'b1;
                    state_next  = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                ctl.load     = (round_reg == 4'd0);
                ctl.last     = (round_reg == 4'(NumRounds));
                ctl.skip_mix = ctl.last;
                if (ctl.last)
                    state_next = ST_DONE;
                else
                begin
                    round_next = round_reg + 4'd1;
                    wsel_next  = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    genvar gc;
    generate
        for (gc = 0; gc < 4; gc++)
        begin : g_cell
            aes_column_cell u_cell (
                .clk         (clk),
                .step        (state_reg == ST_ROUND),
                .ctl         (ctl),
                .load_col    (in_reg[127-32*gc -: 32]),
                .key_col     (state_reg == ST_ROUND ? rk_cur[gc] : 32'd0),
                .shifted_col (state_reg == ST_ROUND ? shifted[gc] : 32'd0),
                .col         (cols[gc])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            round_reg      <= '0;
            wsel_reg       <= '0;
            loaded_reg     <= 1'b0;
            ready_keys_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            round_reg      <= round_next;
            wsel_reg       <= wsel_next;
            loaded_reg     <= loaded_next;
            ready_keys_reg <= ready_keys_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (res.valid && res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            dec_reg <= req.req_type;
            in_reg  <= {req.block_high, req.block_low};
        end
        if (state_reg == ST_FETCH)
        begin
            rk_reg[0] <= rk_reg[1];
            rk_reg[1] <= rk_reg[2];
            rk_reg[2] <= rk_data;
        end
        if (out_load)
            out_reg <= {cols[0], cols[1], cols[2], cols[3]};
    end

    assign res.valid       = out_valid_reg;
    assign res.result_high = out_reg[127:64];
    assign res.result_low  = out_reg[63:0];

    `AES_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !req.ready, "accept while busy")
    `AES_ASSERT_NEXT(a_done_valid, clk, rst_n, state_reg == ST_DONE, res.valid, "result not presented")
    `AES_ASSERT_IMP(a_round_range, clk, rst_n, state_reg == ST_ROUND, round_reg <= 4'(NumRounds), "round overrun")
    `AES_ASSERT_IMP(a_keys_before_round, clk, rst_n, state_reg == ST_ROUND, ready_keys_reg && !exp_busy, "round without keys")
    `AES_ASSERT_IMP(a_round_after_fetch, clk, rst_n, state_reg == ST_ROUND, loaded_reg, "round before key fetch")

endmodule
